@@ src/spfd_pkg.sv @@
// spfd_pkg: shared types and constants for the stereo feedback delay
// payload structs, field widths, register indexes and reset values
// no dependencies
package spfd_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_BITS      = 17;
  localparam int DELAY_BITS     = 24;
  localparam int RAMP_BITS      = 16;
  localparam int EXTRA_BITS     = 8;
  localparam int GAIN_SHIFT     = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  localparam int DEF_STORE_DEPTH     = 65536;
  localparam int DEF_DELAY_FRAC_BITS = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_TARGET  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_LENGTH   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DAMPING_COEFF = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PING_PONG     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIX_GAIN      = 3'd5;

  localparam logic [DELAY_BITS-1:0] RST_DELAY_TARGET  = 24'd12288000;
  localparam logic [RAMP_BITS-1:0]  RST_RAMP_LENGTH   = 16'd4800;
  localparam logic [GAIN_BITS-1:0]  RST_FEEDBACK_GAIN = 17'd32768;
  localparam logic [GAIN_BITS-1:0]  RST_DAMPING_COEFF = 17'd56333;
  localparam logic                  RST_PING_PONG     = 1'b0;
  localparam logic [GAIN_BITS-1:0]  RST_MIX_GAIN      = 17'd32768;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

endpackage

@@ src/spfd_serial_mul.sv @@
// spfd_serial_mul: shift-add multiplier, one multiplier bit per cycle
// signed a times unsigned b, full-width product, done pulses when finished
// depends on spfd_pkg
module spfd_serial_mul import spfd_pkg::*; #(
  parameter int AW = SAMPLE_BITS + 1,
  parameter int BW = GAIN_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic [BW-1:0]           b,
  output logic                    done,
  output logic signed [AW+BW-1:0] product
);

  localparam int CNTW = $clog2(BW + 1);

  logic               busy;
  logic [CNTW-1:0]    cnt;
  logic signed [AW-1:0] a_r;
  logic [BW-1:0]      b_r;
  logic signed [AW-1:0] hi;
  logic [BW-1:0]      lo;
  logic signed [AW:0] sum;

  assign sum = (AW+1)'(hi) + (b_r[0] ? (AW+1)'(a_r) : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        hi   <= '0;
        lo   <= '0;
        cnt  <= CNTW'(BW);
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        hi   <= sum[AW:1];
        lo   <= {sum[0], lo[BW-1:1]};
        b_r  <= b_r >> 1;
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNTW'(1));
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

@@ src/stereo_pingpong_feedback_delay_top.sv @@
// stereo_pingpong_feedback_delay_top: stereo feedback delay with damping
// and ping-pong cross-feed; delay store, delay ramp, bit-serial arithmetic
// depends on spfd_pkg and spfd_serial_mul
//
//   channel | signals                          | moves
//   input   | in_valid, in_stall, in_data      | one stereo pair per transfer
//   output  | out_valid, out_stall, out_data   | one stereo pair per transfer
//   config  | cfg_we, cfg_index, cfg_data      | one register write per cycle
//
// an item runs the delay update, two store reads and four passes of the
// bit-serial multipliers (one per channel)
// a target change with a nonzero ramp length adds the bit-serial ramp step division
// after reset the store is cleared, one entry a cycle, with in_stall high;
// config writes are taken throughout
// a finished pair waits in the output register while the next item runs
module stereo_pingpong_feedback_delay_top import spfd_pkg::*; #(
  parameter int STORE_DEPTH     = DEF_STORE_DEPTH,
  parameter int DELAY_FRAC_BITS = DEF_DELAY_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int S   = SAMPLE_BITS;
  localparam int AWB = $clog2(STORE_DEPTH);
  localparam int AW  = S + 1;
  localparam int PW  = AW + GAIN_BITS;
  localparam int CW  = DELAY_BITS + EXTRA_BITS + 1;
  localparam int DCW = $clog2(CW + 1);
  localparam logic [63:0] MAX_DELAY_L = 64'(STORE_DEPTH - 2) << DELAY_FRAC_BITS;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_ADV, ST_ADDR, ST_RD1, ST_RD2, ST_RD3,
    ST_MUL_GO, ST_MUL_WAIT, ST_WRITE
  } state_t;

  typedef enum logic [1:0] {PH_INTERP, PH_DAMP, PH_FB, PH_MIX} phase_t;

  state_t state;
  phase_t phase;

  // configuration
  logic [DELAY_BITS-1:0] delay_target;
  logic [RAMP_BITS-1:0]  ramp_length;
  logic [GAIN_BITS-1:0]  feedback_gain;
  logic [GAIN_BITS-1:0]  damping_coeff;
  logic                  ping_pong;
  logic [GAIN_BITS-1:0]  mix_gain;

  // delay tracking
  logic                   started;
  logic signed [CW-1:0]   current_delay;
  logic signed [CW-1:0]   ramp_step;
  logic [RAMP_BITS-1:0]   ramp_remaining;
  logic [DELAY_BITS-1:0]  latched_target;
  logic [AWB-1:0]         write_index;
  logic [AWB-1:0]         clr_idx;

  // ramp step divider
  logic [CW-1:0]          div_mag;
  logic [RAMP_BITS-1:0]   div_rem;
  logic                   div_neg;
  logic [DCW-1:0]         div_cnt;
  logic [RAMP_BITS:0]     div_try;
  logic                   div_ge;
  logic [RAMP_BITS-1:0]   div_rem_next;
  logic [CW-1:0]          div_mag_next;

  logic [DELAY_BITS-1:0]  tgt;
  logic signed [CW-1:0]   text;
  logic signed [CW-1:0]   num;
  logic [RAMP_BITS-1:0]   rr_dec;

  // read address
  logic [DELAY_BITS-1:0]  d;
  logic [AWB-1:0]         dint;
  logic [AWB:0]           i1_wide;
  logic [AWB-1:0]         i1;
  logic [AWB-1:0]         i2;
  logic [AWB-1:0]         rd_i1;
  logic [AWB-1:0]         rd_i2;
  logic [DELAY_FRAC_BITS-1:0] frac;

  // store
  logic [2*S-1:0]         mem [STORE_DEPTH];
  logic [2*S-1:0]         rd_data;
  logic                   mem_re;
  logic [AWB-1:0]         mem_ra;
  logic                   mem_we;
  logic [AWB-1:0]         mem_wa;
  logic [2*S-1:0]         mem_wd;
  logic                   out_free;

  logic signed [S-1:0]    in_s   [2];
  logic signed [S-1:0]    v1     [2];
  logic signed [S-1:0]    v2     [2];
  logic signed [S-1:0]    ldel   [2];
  logic signed [S-1:0]    damped [2];
  logic signed [S-1:0]    wr     [2];
  logic signed [S-1:0]    outv   [2];

  logic                   mul_start;
  logic [1:0]             mul_done;

  function automatic logic signed [PW+1:0] rnd(input logic signed [PW-1:0] p, input int s);
    logic signed [PW:0] q;
    q = (PW+1)'(p) + $signed((PW+1)'(1) << (s - 1));
    return (PW+2)'(q >>> s);
  endfunction

  function automatic logic signed [S-1:0] sat(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] hi_lim;
    logic signed [PW+1:0] lo_lim;
    hi_lim = (PW+2)'({1'b0, {(S-1){1'b1}}});
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return {1'b0, {(S-1){1'b1}}};
    if (v < lo_lim) return {1'b1, {(S-1){1'b0}}};
    return v[S-1:0];
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign tgt  = (64'(delay_target) > MAX_DELAY_L) ? MAX_DELAY_L[DELAY_BITS-1:0] : delay_target;
  assign text = $signed({1'b0, tgt, {EXTRA_BITS{1'b0}}});
  assign num  = text - current_delay;
  assign rr_dec = ramp_remaining - 1'b1;

  assign div_try      = {div_rem, div_mag[CW-1]};
  assign div_ge       = div_try >= {1'b0, ramp_length};
  assign div_rem_next = div_ge ? RAMP_BITS'(div_try - {1'b0, ramp_length})
                               : div_try[RAMP_BITS-1:0];
  assign div_mag_next = {div_mag[CW-2:0], div_ge};

  always_comb begin
    d = current_delay[CW-1] ? '0 : current_delay[CW-2:EXTRA_BITS];
    if (64'(d) > MAX_DELAY_L) d = MAX_DELAY_L[DELAY_BITS-1:0];
  end
  assign dint    = AWB'(d >> DELAY_FRAC_BITS);
  assign i1_wide = (write_index >= dint)
                   ? (AWB+1)'(write_index) - (AWB+1)'(dint)
                   : (AWB+1)'(write_index) + (AWB+1)'(STORE_DEPTH) - (AWB+1)'(dint);
  assign i1 = i1_wide[AWB-1:0];
  assign i2 = (i1 == '0) ? AWB'(STORE_DEPTH - 1) : i1 - 1'b1;

  // store ports
  assign mem_re = (state == ST_RD1) || (state == ST_RD2);
  assign mem_ra = (state == ST_RD1) ? rd_i1 : rd_i2;
  assign mem_we = (state == ST_CLEAR) || (state == ST_WRITE && out_free);
  assign mem_wa = (state == ST_CLEAR) ? clr_idx : write_index;
  assign mem_wd = (state == ST_CLEAR) ? '0 : {wr[1], wr[0]};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  assign mul_start = (state == ST_MUL_GO);

  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    logic signed [AW-1:0]    mul_a;
    logic [GAIN_BITS-1:0]    mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [S-1:0]     src;

    assign src = ping_pong ? damped[1-ch] : damped[ch];

    always_comb begin
      case (phase)
        PH_INTERP: begin
          mul_a = AW'(v2[ch]) - AW'(v1[ch]);
          mul_b = GAIN_BITS'(frac);
        end
        PH_DAMP: begin
          mul_a = AW'(ldel[ch]) - AW'(damped[ch]);
          mul_b = damping_coeff;
        end
        PH_FB: begin
          mul_a = AW'(src);
          mul_b = feedback_gain;
        end
        default: begin
          mul_a = AW'(ldel[ch]);
          mul_b = mix_gain;
        end
      endcase
    end

    spfd_serial_mul #(.AW(AW), .BW(GAIN_BITS)) u_mul (
      .clk     (clk),
      .rst     (rst),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done[ch]),
      .product (prod)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        damped[ch] <= '0;
      end else begin
        if (state == ST_IDLE && in_valid) begin
          in_s[ch] <= (ch == 0) ? in_data.left_in : in_data.right_in;
        end
        if (state == ST_RD2) v1[ch] <= rd_data[ch*S +: S];
        if (state == ST_RD3) v2[ch] <= rd_data[ch*S +: S];
        if (state == ST_MUL_WAIT && mul_done[ch]) begin
          case (phase)
            PH_INTERP: ldel[ch] <= S'((PW+2)'(v1[ch]) + rnd(prod, DELAY_FRAC_BITS));
            PH_DAMP:   damped[ch] <= sat((PW+2)'(damped[ch]) + rnd(prod, GAIN_SHIFT));
            PH_FB:     wr[ch] <= sat((PW+2)'(in_s[ch]) + rnd(prod, GAIN_SHIFT));
            default:   outv[ch] <= sat((PW+2)'(in_s[ch]) + rnd(prod, GAIN_SHIFT));
          endcase
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_target  <= RST_DELAY_TARGET;
      ramp_length   <= RST_RAMP_LENGTH;
      feedback_gain <= RST_FEEDBACK_GAIN;
      damping_coeff <= RST_DAMPING_COEFF;
      ping_pong     <= RST_PING_PONG;
      mix_gain      <= RST_MIX_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_TARGET:  delay_target  <= cfg_data[DELAY_BITS-1:0];
        REG_RAMP_LENGTH:   ramp_length   <= cfg_data[RAMP_BITS-1:0];
        REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[GAIN_BITS-1:0];
        REG_DAMPING_COEFF: damping_coeff <= cfg_data[GAIN_BITS-1:0];
        REG_PING_PONG:     ping_pong     <= cfg_data[0];
        REG_MIX_GAIN:      mix_gain      <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      phase          <= PH_INTERP;
      clr_idx        <= '0;
      started        <= 1'b0;
      current_delay  <= '0;
      ramp_step      <= '0;
      ramp_remaining <= '0;
      latched_target <= '0;
      write_index    <= '0;
      div_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_WRITE) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AWB'(STORE_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (!started) begin
              current_delay  <= text;
              ramp_remaining <= '0;
              latched_target <= tgt;
              started        <= 1'b1;
              state          <= ST_ADV;
            end else if (tgt != latched_target) begin
              latched_target <= tgt;
              if (ramp_length == '0) begin
                current_delay  <= text;
                ramp_remaining <= '0;
                state          <= ST_ADV;
              end else begin
                ramp_remaining <= ramp_length;
                div_neg <= num[CW-1];
                div_mag <= num[CW-1] ? CW'(-num) : CW'(num);
                div_rem <= '0;
                div_cnt <= DCW'(CW);
                state   <= ST_DIV;
              end
            end else begin
              state <= ST_ADV;
            end
          end
        end
        ST_DIV: begin
          div_rem <= div_rem_next;
          div_mag <= div_mag_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCW'(1)) begin
            ramp_step <= div_neg ? -$signed(div_mag_next) : $signed(div_mag_next);
            state     <= ST_ADV;
          end
        end
        ST_ADV: begin
          if (ramp_remaining != '0) begin
            ramp_remaining <= rr_dec;
            if (rr_dec != '0) current_delay <= current_delay + ramp_step;
            else current_delay <= $signed({1'b0, latched_target, {EXTRA_BITS{1'b0}}});
          end
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          rd_i1 <= i1;
          rd_i2 <= i2;
          frac  <= d[DELAY_FRAC_BITS-1:0];
          state <= ST_RD1;
        end
        ST_RD1: state <= ST_RD2;
        ST_RD2: state <= ST_RD3;
        ST_RD3: begin
          phase <= PH_INTERP;
          state <= ST_MUL_GO;
        end
        ST_MUL_GO: state <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done[0]) begin
            case (phase)
              PH_INTERP: begin
                phase <= PH_DAMP;
                state <= ST_MUL_GO;
              end
              PH_DAMP: begin
                phase <= PH_FB;
                state <= ST_MUL_GO;
              end
              PH_FB: begin
                phase <= PH_MIX;
                state <= ST_MUL_GO;
              end
              default: state <= ST_WRITE;
            endcase
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            out_data.left_out  <= outv[0];
            out_data.right_out <= outv[1];
            out_valid   <= 1'b1;
            write_index <= (write_index == AWB'(STORE_DEPTH - 1)) ? '0
                           : write_index + 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/spfd_checker.sv @@
// spfd_checker: port-level checks on the stereo feedback delay
// bound to stereo_pingpong_feedback_delay_top; depends on spfd_pkg
module spfd_checker import spfd_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input in_item_t                  in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input out_item_t                 out_data,
  input logic                      cfg_we,
  input logic [CFG_INDEX_BITS-1:0] cfg_index,
  input logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  // store clear blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("input taken during store clear");

  // one item at a time
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // no result appears right after a transfer in
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind stereo_pingpong_feedback_delay_top spfd_checker u_spfd_checker (.*);

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for stereo_pingpong_feedback_delay_top
// predicts each output pair from its own delay model and compares per field
// depends on spfd_pkg and the top level rtl
`timescale 1ns / 1ps

module tb_top;
  import spfd_pkg::*;

  localparam int DEPTH = DEF_STORE_DEPTH;
  localparam int FRAC = DEF_DELAY_FRAC_BITS;
  localparam longint SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint MAX_DLY = longint'(DEPTH - 2) <<< FRAC;
  localparam longint LIMIT = 64'd4000000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  stereo_pingpong_feedback_delay_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and state
  logic [23:0] p_target;
  logic [15:0] p_ramp_len;
  logic [16:0] p_fb, p_damp, p_mix;
  logic p_pp;
  longint lstore[DEPTH], rstore[DEPTH];
  int unsigned widx;
  longint ldamp, rdamp, cur_delay, ramp_step, latched;
  int unsigned ramp_left;
  bit started;

  out_item_t pair_q[$];
  int errors, checked, sent;
  int send_idle_pct, stall_pct;
  bit hold_off;
  longint cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip(longint v);
    return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
  endfunction

  function automatic longint rnd_shift(longint p, int s);
    longint q;
    q = p + (64'sd1 <<< (s - 1));
    return q >>> s;
  endfunction

  function automatic longint tap(ref longint st[DEPTH], input longint di, input longint fr);
    longint v1, v2;
    v1 = st[(widx + DEPTH - di) % DEPTH];
    v2 = st[(widx + 2 * DEPTH - di - 1) % DEPTH];
    return v1 + rnd_shift((v2 - v1) * fr, FRAC);
  endfunction

  function automatic out_item_t delay_pair(in_item_t it);
    longint tgt, text, d, di, fr, lin, rin, ld, rd, ls, rs;
    out_item_t o;
    lin = longint'(it.left_in);
    rin = longint'(it.right_in);
    tgt = longint'(p_target);
    if (tgt > MAX_DLY) tgt = MAX_DLY;
    text = tgt <<< 8;
    if (!started) begin
      cur_delay = text; ramp_left = 0; latched = tgt; started = 1;
    end else if (tgt != latched) begin
      latched = tgt;
      if (p_ramp_len == 0) begin
        cur_delay = text; ramp_left = 0;
      end else begin
        ramp_step = (text - cur_delay) / longint'(p_ramp_len);
        ramp_left = p_ramp_len;
      end
    end
    if (ramp_left != 0) begin
      ramp_left--;
      if (ramp_left != 0) cur_delay += ramp_step;
      else cur_delay = latched <<< 8;
    end
    d = cur_delay < 0 ? 0 : (cur_delay >>> 8);
    if (d > MAX_DLY) d = MAX_DLY;
    di = d >>> FRAC;
    fr = d & ((64'sd1 <<< FRAC) - 1);
    ld = tap(lstore, di, fr);
    rd = tap(rstore, di, fr);
    ldamp = clip(ldamp + rnd_shift((ld - ldamp) * longint'(p_damp), GAIN_SHIFT));
    rdamp = clip(rdamp + rnd_shift((rd - rdamp) * longint'(p_damp), GAIN_SHIFT));
    ls = p_pp ? rdamp : ldamp;
    rs = p_pp ? ldamp : rdamp;
    lstore[widx] = clip(lin + rnd_shift(ls * longint'(p_fb), GAIN_SHIFT));
    rstore[widx] = clip(rin + rnd_shift(rs * longint'(p_fb), GAIN_SHIFT));
    widx = (widx + 1) % DEPTH;
    o.left_out = SAMPLE_BITS'(clip(lin + rnd_shift(ld * longint'(p_mix), GAIN_SHIFT)));
    o.right_out = SAMPLE_BITS'(clip(rin + rnd_shift(rd * longint'(p_mix), GAIN_SHIFT)));
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at pair %0d: got %0d expected %0d", what, checked, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val[CFG_DATA_BITS-1:0];
    case (idx)
      REG_DELAY_TARGET:  p_target = val[23:0];
      REG_RAMP_LENGTH:   p_ramp_len = val[15:0];
      REG_FEEDBACK_GAIN: p_fb = val[16:0];
      REG_DAMPING_COEFF: p_damp = val[16:0];
      REG_PING_PONG:     p_pp = val[0];
      REG_MIX_GAIN:      p_mix = val[16:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_pair(logic [23:0] l, logic [23:0] r);
    in_item_t it;
    it.left_in = l; it.right_in = r;
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1; in_data <= it;
    pair_q.push_back(delay_pair(it));
    sent++;
    do @(posedge clk); while (in_stall);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (pair_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [23:0] rsamp();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(15));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [23:0] ext[4] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
    write_reg(REG_DELAY_TARGET, 24'd768);
    write_reg(REG_RAMP_LENGTH, 16'd0);
    write_reg(REG_FEEDBACK_GAIN, 17'd65536);
    write_reg(REG_DAMPING_COEFF, 17'd65536);
    write_reg(REG_MIX_GAIN, 17'd65536);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) send_pair(ext[i], ext[j]);
    drain();
    // sub-sample delay reads the oldest entry
    write_reg(REG_DELAY_TARGET, 24'd100);
    write_reg(REG_PING_PONG, 1);
    for (int i = 0; i < 4; i++) send_pair(ext[i], ext[3 - i]);
    drain();
    // target beyond store depth gets clamped
    write_reg(REG_DELAY_TARGET, 24'hFFFFFF);
    for (int i = 0; i < 4; i++) send_pair(ext[i], ext[i]);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    send_idle_pct = idle; stall_pct = stall;
    write_reg(REG_DELAY_TARGET, $urandom_range(1, 3) == 1 ? 24'd256
        : (($urandom_range(1, 40) << 8) | $urandom_range(255)));
    write_reg(REG_RAMP_LENGTH, $urandom_range(1, 1) ? $urandom_range(0, 20) : 16'hFFFF);
    write_reg(REG_FEEDBACK_GAIN, $urandom_range(65536));
    write_reg(REG_DAMPING_COEFF, $urandom_range(65536));
    write_reg(REG_PING_PONG, $urandom_range(1));
    write_reg(REG_MIX_GAIN, $urandom_range(65536));
    for (int i = 0; i < n; i++) send_pair(rsamp(), rsamp());
    drain();
  endtask

  task automatic test_ramp_extremes();
    send_idle_pct = 0; stall_pct = 0;
    write_reg(REG_RAMP_LENGTH, 16'hFFFF);
    write_reg(REG_DELAY_TARGET, 24'd16776704);
    for (int i = 0; i < 20; i++) send_pair(rsamp(), rsamp());
    drain();
    write_reg(REG_RAMP_LENGTH, 16'd5);
    write_reg(REG_DELAY_TARGET, 24'd256);
    for (int i = 0; i < 20; i++) send_pair(rsamp(), rsamp());
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; stall_pct = 0;
    hold_off = 1;
    for (int i = 0; i < 10; i++) send_pair(rsamp(), rsamp());
    while (hold_off) @(posedge clk);
    drain();
  endtask

  // long receiver hold-off counted on its own
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    int cnt;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        cnt = 0;
        while (cnt < 2000) begin
          @(posedge clk);
          cnt++;
        end
        hold_off = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pair_q.size() == 0) begin
        report_mismatch("unexpected pair", longint'(out_data.left_out), 0);
      end else begin
        out_item_t e;
        e = pair_q.pop_front();
        if (out_data.left_out !== e.left_out)
          report_mismatch("left_out", out_data.left_out, e.left_out);
        if (out_data.right_out !== e.right_out)
          report_mismatch("right_out", out_data.right_out, e.right_out);
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout with %0d pairs pending", pair_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    cycles = 0; errors = 0; checked = 0; sent = 0;
    send_idle_pct = 0; stall_pct = 0; hold_off = 0;
    rst = 1; in_valid = 0; in_data = '0;
    cfg_we = 0; cfg_index = REG_DELAY_TARGET; cfg_data = '0;
    p_target = RST_DELAY_TARGET; p_ramp_len = RST_RAMP_LENGTH;
    p_fb = RST_FEEDBACK_GAIN; p_damp = RST_DAMPING_COEFF;
    p_pp = RST_PING_PONG; p_mix = RST_MIX_GAIN;
    for (int i = 0; i < DEPTH; i++) begin
      lstore[i] = 0; rstore[i] = 0;
    end
    widx = 0; ldamp = 0; rdamp = 0; cur_delay = 0; ramp_step = 0;
    latched = 0; ramp_left = 0; started = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    test_directed();
    test_ramp_extremes();
    test_backpressure();
    for (int k = 0; k < 2; k++) begin
      test_random_phase(110, 0, 0);
      test_random_phase(110, 49, 0);
      test_random_phase(110, 0, 49);
      test_random_phase(110, 19, 19);
    end
    $display("covered %0d stereo pairs over directed extremes, ramps, clamping,", sent);
    $display("ping-pong, back-pressure and random gains; %0d pairs checked", checked);
    if (errors == 0 && pair_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
